// ===== hw/rtl/dhcpomf_pkg.sv =====
// dhcpomf_pkg: shared types and constants for the dhcp option match filter
// used by dhcpomf_core and dhcp_option_match_filter; no dependencies
`timescale 1ns / 1ps

package dhcpomf_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_CODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_VALUE = 2'd3;
  localparam int unsigned CFG_DATA_W = 8;

  // verdict status codes
  localparam logic [2:0] ST_MATCH       = 3'd0;
  localparam logic [2:0] ST_NOT_UDP     = 3'd1;
  localparam logic [2:0] ST_FRAGMENT    = 3'd2;
  localparam logic [2:0] ST_SHORT       = 3'd3;
  localparam logic [2:0] ST_NOT_REQUEST = 3'd4;
  localparam logic [2:0] ST_BAD_COOKIE  = 3'd5;
  localparam logic [2:0] ST_NO_MATCH    = 3'd6;

  // protocol constants
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  BOOTP_REQUEST = 8'h01;
  localparam logic [31:0] DHCP_COOKIE   = 32'h6382_5363;
  localparam logic [7:0]  OPT_END       = 8'd255;
  localparam logic [7:0]  OPT_PAD       = 8'd0;
  localparam logic [15:0] MIN_UDP_LEN   = 16'd248;
  localparam logic [15:0] IDX_MAX       = 16'hFFFF;

  // configuration registers as one bundle
  typedef struct packed {
    logic [7:0] match_code;
    logic [7:0] match_value;
    logic       invert_code;
    logic       invert_value;
  } cfg_t;

  // one verdict
  typedef struct packed {
    logic       matched;
    logic [2:0] status;
  } res_t;

endpackage

// ===== hw/rtl/dhcp_option_match_filter.sv =====
// dhcp_option_match_filter: top level with config registers and output skid
// depends on dhcpomf_pkg and dhcpomf_core
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_stall, in_data_byte, in_last_byte) carries an
//   IPv4 packet one byte per item, IP header first; in_last_byte marks the end.
//   Output channel (out_valid/out_stall, out_matched, out_status) gives one
//   verdict item per packet, produced by its last byte.
//   Config port (cfg_we, cfg_index, cfg_data) writes match code, match value
//   and the two invert bits; write only while no packet is in flight.
// Output: the verdict is registered into the output register, or into the
//   skid slot while the output register holds a verdict not yet taken.
// Throughput: one byte per cycle when not stalled; one compare-and-update
//   of its packet state per byte, so back-to-back packets run at full rate.
// Reset: rst_n clears config, packet state and both output slots.
// Stall: an output register plus a one-entry skid hold verdicts; in_stall
//   rises only while the skid slot is occupied.
//
module dhcp_option_match_filter
  import dhcpomf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_matched,
  output logic [2:0]            out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  res_t out_r, out_nxt, skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic take, out_take;
  logic res_valid;
  res_t res;

  assign in_stall = skid_valid_r;
  assign take     = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_CODE:   cfg_nxt.match_code   = cfg_data;
        CFG_MATCH_VALUE:  cfg_nxt.match_value  = cfg_data;
        CFG_INVERT_CODE:  cfg_nxt.invert_code  = cfg_data[0];
        CFG_INVERT_VALUE: cfg_nxt.invert_value = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  dhcpomf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register and skid slot
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_nxt       = res;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = res_valid;
      out_nxt       = res;
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // verdict payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_r.matched;
  assign out_status  = out_r.status;

endmodule

// ===== hw/rtl/dhcpomf_core.sv =====
// dhcpomf_core: per-byte packet parser and dhcp option walker
// depends on dhcpomf_pkg; one byte is consumed per accept strobe
`timescale 1ns / 1ps

module dhcpomf_core
  import dhcpomf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  // option walk phases
  typedef enum logic [3:0] {
    PH_CODE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_VAL  = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_t;

  logic [15:0] byte_index_r, byte_index_nxt;
  logic [5:0]  header_bytes_r, header_bytes_nxt;
  logic [15:0] udp_length_r, udp_length_nxt;
  logic [31:0] cookie_r, cookie_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  status_r, status_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [16:0] hb_ext;
  logic [15:0] walk_pos;
  logic [15:0] region_len;
  logic        any_fail;
  logic [2:0]  fail_st;
  logic        walk_en;
  logic        code_m, value_m;
  logic        code_fits;
  logic [2:0]  final_st;

  assign hb_ext     = {11'd0, header_bytes_r};
  assign walk_pos   = byte_index_r - {10'd0, header_bytes_r} - MIN_UDP_LEN;
  assign region_len = udp_length_r - MIN_UDP_LEN;
  assign code_m     = (held_r == cfg.match_code) ^ cfg.invert_code;
  assign value_m    = (data_byte == cfg.match_value) ^ cfg.invert_value;
  assign code_fits  = ({1'b0, walk_pos} + 17'd2) < {1'b0, region_len};

  always_comb begin
    byte_index_nxt   = byte_index_r;
    header_bytes_nxt = header_bytes_r;
    udp_length_nxt   = udp_length_r;
    cookie_nxt       = cookie_r;
    done_nxt         = done_r;
    status_nxt       = status_r;
    phase_nxt        = phase_r;
    skip_nxt         = skip_r;
    held_nxt         = held_r;
    any_fail         = 1'b0;
    fail_st          = ST_NO_MATCH;
    walk_en          = 1'b0;
    final_st         = ST_NO_MATCH;

    if (take && byte_index_r != IDX_MAX) begin
      cookie_nxt     = {cookie_r[23:0], data_byte};
      byte_index_nxt = byte_index_r + 16'd1;
      if (byte_index_r == 16'd0) begin
        header_bytes_nxt = {data_byte[3:0], 2'b00};
      end
      if ({1'b0, byte_index_r} == hb_ext + 17'd5) begin
        udp_length_nxt = {cookie_r[7:0], data_byte};
      end

      // header checks, lowest status code wins
      if (byte_index_r == 16'd9 && data_byte != PROTO_UDP) begin
        any_fail = 1'b1;
        fail_st  = ST_NOT_UDP;
      end else if (byte_index_r == 16'd7 && {cookie_r[4:0], data_byte} != 13'd0) begin
        any_fail = 1'b1;
        fail_st  = ST_FRAGMENT;
      end else if ({1'b0, byte_index_r} == hb_ext + 17'd5 &&
                   {cookie_r[7:0], data_byte} < MIN_UDP_LEN) begin
        any_fail = 1'b1;
        fail_st  = ST_SHORT;
      end else if ({1'b0, byte_index_r} == hb_ext + 17'd8 && data_byte != BOOTP_REQUEST) begin
        any_fail = 1'b1;
        fail_st  = ST_NOT_REQUEST;
      end else if ({1'b0, byte_index_r} == hb_ext + 17'd247 &&
                   {cookie_r[23:0], data_byte} != DHCP_COOKIE) begin
        any_fail = 1'b1;
        fail_st  = ST_BAD_COOKIE;
      end

      if (any_fail) begin
        if (!done_r || fail_st < status_r) begin
          status_nxt = fail_st;
        end
        done_nxt = 1'b1;
      end

      // option walk once the bootp header is behind us
      walk_en = ({1'b0, byte_index_r} >= hb_ext + {1'b0, MIN_UDP_LEN}) && !done_nxt;
      if (walk_en) begin
        if (walk_pos >= region_len) begin
          done_nxt   = 1'b1;
          status_nxt = ST_NO_MATCH;
        end else begin
          case (phase_r)
            PH_LEN: begin
              skip_nxt  = data_byte;
              phase_nxt = PH_VAL;
            end
            PH_VAL: begin
              if (code_m && value_m) begin
                done_nxt   = 1'b1;
                status_nxt = ST_MATCH;
              end else if (skip_r == 8'd0) begin
                // zero length: value byte is also the next code
                if (data_byte == OPT_END) begin
                  done_nxt   = 1'b1;
                  status_nxt = ST_NO_MATCH;
                end else if (data_byte == OPT_PAD) begin
                  phase_nxt = PH_CODE;
                end else if (!code_fits) begin
                  done_nxt   = 1'b1;
                  status_nxt = ST_NO_MATCH;
                end else begin
                  held_nxt  = data_byte;
                  phase_nxt = PH_LEN;
                end
              end else if (skip_r == 8'd1) begin
                phase_nxt = PH_CODE;
              end else begin
                skip_nxt  = skip_r - 8'd1;
                phase_nxt = PH_SKIP;
              end
            end
            PH_SKIP: begin
              skip_nxt = skip_r - 8'd1;
              if (skip_r == 8'd1) begin
                phase_nxt = PH_CODE;
              end
            end
            default: begin
              if (data_byte == OPT_END) begin
                done_nxt   = 1'b1;
                status_nxt = ST_NO_MATCH;
              end else if (data_byte == OPT_PAD) begin
                phase_nxt = PH_CODE;
              end else if (!code_fits) begin
                done_nxt   = 1'b1;
                status_nxt = ST_NO_MATCH;
              end else begin
                held_nxt  = data_byte;
                phase_nxt = PH_LEN;
              end
            end
          endcase
        end
      end
    end

    // verdict on the last byte, then clear per-packet state
    if (done_nxt) begin
      final_st = status_nxt;
    end
    if (take && last_byte) begin
      byte_index_nxt   = 16'd0;
      header_bytes_nxt = 6'd0;
      udp_length_nxt   = 16'd0;
      cookie_nxt       = 32'd0;
      done_nxt         = 1'b0;
      status_nxt       = ST_NO_MATCH;
      phase_nxt        = PH_CODE;
      skip_nxt         = 8'd0;
      held_nxt         = 8'd0;
    end
  end

  assign res_valid   = take && last_byte;
  assign res.matched = (final_st == ST_MATCH);
  assign res.status  = final_st;

  // per-packet state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= 16'd0;
      header_bytes_r <= 6'd0;
      udp_length_r   <= 16'd0;
      cookie_r       <= 32'd0;
      done_r         <= 1'b0;
      status_r       <= ST_NO_MATCH;
      phase_r        <= PH_CODE;
      skip_r         <= 8'd0;
      held_r         <= 8'd0;
    end else begin
      byte_index_r   <= byte_index_nxt;
      header_bytes_r <= header_bytes_nxt;
      udp_length_r   <= udp_length_nxt;
      cookie_r       <= cookie_nxt;
      done_r         <= done_nxt;
      status_r       <= status_nxt;
      phase_r        <= phase_nxt;
      skip_r         <= skip_nxt;
      held_r         <= held_nxt;
    end
  end

endmodule
